>>> design/dsil_pkg.sv
// Shared constants, codes and types for the descending sorted insert list.
package dsil_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VAL_W         = 7;
    localparam int POS_W         = 6;
    localparam int STAT_W        = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUMPED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             rot;
        logic [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

>>> design/dsil_cell.sv
// One storage cell of the sorted chain: compare, shift on insert, rotate on dump.
module dsil_cell (
    input  logic                       i_clk,
    input  dsil_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_valid,
    input  logic                       i_tail,
    input  logic                       i_left_ge,
    input  logic [dsil_pkg::VAL_W-1:0] i_left_value,
    input  logic [dsil_pkg::VAL_W-1:0] i_right_value,
    input  logic [dsil_pkg::VAL_W-1:0] i_head_value,
    output logic [dsil_pkg::VAL_W-1:0] o_value,
    output logic                       o_ge,
    output logic                       o_land
);
    import dsil_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    // A stored value at or above the new one stays where it is.
    assign o_ge   = i_valid && (r_value >= i_ctrl.value);
    assign o_land = i_left_ge && !o_ge;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins && !o_ge) begin
            n_value = i_left_ge ? i_ctrl.value : i_left_value;
        end else if (i_ctrl.rot) begin
            n_value = i_tail ? i_head_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> design/dsil_chain.sv
// Row of sorted cells with neighbor wiring and the landing slot encoder.
module dsil_chain #(
    parameter int DEPTH = dsil_pkg::DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  dsil_pkg::t_cell_ctrl       i_ctrl,
    input  logic [CW-1:0]              i_count,
    output logic [dsil_pkg::VAL_W-1:0] o_head_value,
    output logic [IW-1:0]              o_land_pos
);
    import dsil_pkg::*;

    logic [VAL_W-1:0] w_value [DEPTH];
    logic [DEPTH-1:0] w_ge;
    logic [DEPTH-1:0] w_land;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic             w_valid;
        logic             w_tail;
        logic             w_left_ge;
        logic [VAL_W-1:0] w_left_value;
        logic [VAL_W-1:0] w_right_value;

        assign w_valid = CW'(i) < i_count;
        assign w_tail  = CW'(i + 1) == i_count;

        if (i == 0) begin : g_first
            assign w_left_ge    = 1'b1;
            assign w_left_value = i_ctrl.value;
        end else begin : g_inner
            assign w_left_ge    = w_ge[i-1];
            assign w_left_value = w_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_right_value = w_value[0];
        end else begin : g_mid
            assign w_right_value = w_value[i+1];
        end

        dsil_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (i_ctrl),
            .i_valid       (w_valid),
            .i_tail        (w_tail),
            .i_left_ge     (w_left_ge),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .i_head_value  (w_value[0]),
            .o_value       (w_value[i]),
            .o_ge          (w_ge[i]),
            .o_land        (w_land[i])
        );
    end

    assign o_head_value = w_value[0];

    // The landing vector is one-hot when the store has room.
    always_comb begin
        o_land_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_land[i]) begin
                o_land_pos = o_land_pos | IW'(i);
            end
        end
    end

endmodule

>>> design/descending_sorted_insert_list_top.sv
// Top level of the descending sorted insert list with stream handshakes.
//
// The block keeps up to DEPTH 7-bit values in descending order in a row of
// cells. Input transactions arrive on the s_axis group: tuser is the kind
// (insert or dump) and tdata[6:0] the value. Results leave on the m_axis
// group: tuser[1:0] is the status, tdata[6:0] the value, tdata[12:7] the
// position, and tlast marks the final result of an input transaction.
// An insert needs no stepping: every cell compares against the new value
// at once and the smaller values shift down by one cell, so its single
// result is ready in the output register in the cycle after acceptance and a
// new insert can be taken in every cycle while the receiver keeps up.
// A dump rotates the chain toward cell 0, one entry per cycle while the
// receiver keeps up: each step emits the entry in cell 0, the rotation
// restores the original order, and input is taken again once the last
// entry has entered the output register. No input is accepted during a dump. An
// insert into a full store and a dump of an empty store each give one
// flagged result. When the receiver stalls, the output register holds its
// result and the chain stops rotating; input is refused until the register
// can be freed. Reset empties the store (the fill count returns to zero)
// and clears the output valid; the cell contents need no clearing.
module descending_sorted_insert_list_top #(
    parameter int DEPTH = dsil_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // value[6:0], zero [7]
    input  logic        i_s_axis_tuser,   // kind[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // entry_value[6:0], position[12:7], zero [15:13]
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    output logic        o_m_axis_tlast
);
    import dsil_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    logic                r_ovalid;
    logic [STAT_W-1:0]   r_status;
    logic [VAL_W-1:0]    r_value;
    logic [POS_W-1:0]    r_pos;
    logic                r_last;

    logic                w_out_free;
    logic                w_out_load;
    logic                w_s_acc;
    logic                w_kind;
    logic [VAL_W-1:0]    w_in_value;
    logic                w_full;
    logic                w_dump_last;
    t_cell_ctrl          w_ctrl;
    logic [VAL_W-1:0]    w_head_value;
    logic [IW-1:0]       w_land_pos;

    // The output register can take a new result this cycle.
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_kind          = i_s_axis_tuser;
    assign w_in_value      = i_s_axis_tdata[VAL_W-1:0];
    assign w_full          = r_count == CW'(DEPTH);
    assign w_dump_last     = (CW'(r_idx) + CW'(1)) == r_count;

    assign w_ctrl.ins   = w_s_acc && (w_kind == KIND_INSERT) && !w_full;
    assign w_ctrl.rot   = (r_state == S_DUMP) && w_out_free;
    assign w_ctrl.value = w_in_value;

    // A new result enters the output register on an insert, on a dump of an
    // empty store, and on every step of a running dump.
    assign w_out_load = (w_s_acc && ((w_kind == KIND_INSERT) || (r_count == '0)))
                        || w_ctrl.rot;

    dsil_chain #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_count      (r_count),
        .o_head_value (w_head_value),
        .o_land_pos   (w_land_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        if (w_kind == KIND_INSERT) begin
                            r_value  <= w_in_value;
                            r_last   <= 1'b1;
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_pos    <= '0;
                            end else begin
                                r_status <= ST_INSERTED;
                                r_pos    <= POS_W'(w_land_pos);
                                r_count  <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                            r_value  <= '0;
                            r_pos    <= '0;
                            r_last   <= 1'b1;
                        end else begin
                            r_state <= S_DUMP;
                            r_idx   <= '0;
                        end
                    end
                end
                S_DUMP: begin
                    // Each emitted entry rotates the chain by one cell.
                    if (w_out_free) begin
                        r_status <= ST_DUMPED;
                        r_value  <= w_head_value;
                        r_pos    <= POS_W'(r_idx);
                        r_last   <= w_dump_last;
                        r_idx    <= r_idx + IW'(1);
                        if (w_dump_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(16 - VAL_W - POS_W){1'b0}}, r_pos, r_value};
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_last;

    // The fill count never passes the capacity of the chain.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond capacity");

    // An insert with room grows the store by exactly one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && (w_kind == KIND_INSERT) && !w_full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the store");

    // A dump leaves the fill count unchanged while it streams.
    a_dump_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |=> $stable(r_count))
        else $error("fill count changed during a dump");

    // A dumped entry with the last marker ends the dump.
    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) && w_out_free && w_dump_last
        |=> (r_state == S_IDLE) && r_last && (r_status == ST_DUMPED))
        else $error("dump did not end on its last entry");

endmodule

>>> verif/tb_descending_sorted_insert_list_top.sv
// Self-checking testbench for the descending sorted insert list top level.
`timescale 1ns / 100ps

module tb_descending_sorted_insert_list_top;

    import dsil_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    // The worst case is every item a full dump (DEPTH results) and every result
    // waiting out the longest receiver stall. Several times that is allowed.
    localparam int CYCLE_LIMIT = 1_500_000;
    // Cycles allowed after the last expected result to catch any extra output.
    localparam int TAIL_CYCLES = 2 * DEPTH + 20;
    localparam int MAX_PRINTS  = 40;

    // One input transaction: the kind goes on tuser, the value on tdata.
    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
    } list_cmd_t;

    // One output transaction, split into its fields.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
        logic              last;
    } list_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;      // value[6:0], zero [7]
    logic        i_s_axis_tuser = 1'b0;    // kind[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // entry_value[6:0], position[12:7], zero [15:13]
    logic [1:0]  o_m_axis_tuser;           // status[1:0]
    logic        o_m_axis_tlast;

    descending_sorted_insert_list_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Input transactions waiting for the driver, and the results that the
    // shadow list says must come out, oldest first.
    list_cmd_t    stim_items[$];
    list_result_t awaited_results[$];
    int           queued_values[$];

    // Shadow copy of the store: the values in descending order and their count.
    logic [VAL_W-1:0] shadow_list[DEPTH];
    int               shadow_fill = 0;

    int err_count       = 0;
    int cycle_count     = 0;
    int results_checked = 0;
    int n_inserted      = 0;
    int n_dropped       = 0;
    int n_dumps         = 0;
    int n_empty_dumps   = 0;

    // Driver and receiver pacing state.
    list_cmd_t drv_cmd;
    int        drv_gap   = 0;
    int        drv_calm  = 0;
    int        mon_stall = 0;
    int        mon_calm  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Value for a random insert. Some repeat earlier values so that equal
    // keys meet in the list; some hit the ends of the range.
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r < 4 && queued_values.size() > 0) begin
            return VAL_W'(queued_values[$urandom_range(0, queued_values.size() - 1)]);
        end
        return VAL_W'($urandom_range(0, 127));
    endfunction

    task automatic queue_insert(input logic [VAL_W-1:0] v);
        list_cmd_t c;
        c.kind  = KIND_INSERT;
        c.value = v;
        stim_items.push_back(c);
        queued_values.push_back(int'(v));
    endtask

    // A dump ignores its value field, so random bits are sent there.
    task automatic queue_dump();
        list_cmd_t c;
        c.kind  = KIND_DUMP;
        c.value = VAL_W'($urandom_range(0, 127));
        stim_items.push_back(c);
    endtask

    // Applies one accepted transaction to the shadow list and appends the
    // results it must cause. An insert lands after every value that is
    // greater than or equal to it; a full list drops it with a flag.
    task automatic step_shadow_list(input list_cmd_t cmd);
        list_result_t r;
        int           slot;
        if (cmd.kind == KIND_INSERT) begin
            if (shadow_fill >= DEPTH) begin
                r.status   = ST_FULL;
                r.value    = cmd.value;
                r.position = '0;
                r.last     = 1'b1;
                awaited_results.push_back(r);
                n_dropped++;
            end else begin
                slot = 0;
                while (slot < shadow_fill && shadow_list[slot] >= cmd.value) begin
                    slot++;
                end
                for (int i = shadow_fill; i > slot; i--) begin
                    shadow_list[i] = shadow_list[i-1];
                end
                shadow_list[slot] = cmd.value;
                shadow_fill++;
                r.status   = ST_INSERTED;
                r.value    = cmd.value;
                r.position = POS_W'(slot);
                r.last     = 1'b1;
                awaited_results.push_back(r);
                n_inserted++;
            end
        end else if (shadow_fill == 0) begin
            r.status   = ST_EMPTY;
            r.value    = '0;
            r.position = '0;
            r.last     = 1'b1;
            awaited_results.push_back(r);
            n_empty_dumps++;
        end else begin
            for (int i = 0; i < shadow_fill; i++) begin
                r.status   = ST_DUMPED;
                r.value    = shadow_list[i];
                r.position = POS_W'(i);
                r.last     = (i == shadow_fill - 1);
                awaited_results.push_back(r);
            end
            n_dumps++;
        end
    endtask

    // One line per mismatch, with the print count capped so that a broken
    // block cannot flood the log; every mismatch is still counted.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        err_count++;
    endtask

    task automatic check_result();
        list_result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result, status", int'(o_m_axis_tuser), -1);
        end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (o_m_axis_tuser !== want.status) begin
                report_mismatch("status", int'(o_m_axis_tuser), int'(want.status));
            end
            if (o_m_axis_tdata[6:0] !== want.value) begin
                report_mismatch("entry_value", int'(o_m_axis_tdata[6:0]), int'(want.value));
            end
            if (o_m_axis_tdata[12:7] !== want.position) begin
                report_mismatch("position", int'(o_m_axis_tdata[12:7]), int'(want.position));
            end
            if (o_m_axis_tlast !== want.last) begin
                report_mismatch("last", int'(o_m_axis_tlast), int'(want.last));
            end
        end
    endtask

    // Blocks the stimulus until every queued transaction has been accepted
    // and every result it caused has been seen.
    task automatic wait_drained();
        while (stim_items.size() != 0 || i_s_axis_tvalid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: holds each transaction until the block takes it, then idles for
    // a random gap. A calm stretch now and then sends back to back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                step_shadow_list(drv_cmd);
            end
            if (drv_calm > 0) begin
                drv_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
                drv_calm = $urandom_range(30, 120);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (stim_items.size() > 0) begin
                    drv_cmd = stim_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {1'b0, drv_cmd.value};
                    i_s_axis_tuser  <= drv_cmd.kind;
                    drv_gap = (drv_calm > 0) ? 0 : pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and stalls the block at random.
    // The ready may fall while a result is offered, which the stream allows.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            if (mon_calm > 0) begin
                mon_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
                mon_calm = $urandom_range(30, 150);
            end
            if (mon_calm > 0) begin
                i_m_axis_tready <= 1'b1;
            end else if (mon_stall > 0) begin
                mon_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                mon_stall = pick_gap();
                if (mon_stall > 0) begin
                    mon_stall--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[descending_sorted_insert_list_top] ERROR");
            $finish;
        end
    end

    initial begin
        int n_random;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: a dump of the empty store, the range ends, equal
        // values at the top, in the middle and at the bottom of the list,
        // and dumps of a partly filled store.
        queue_dump();
        queue_insert(7'd0);
        queue_insert(7'd127);
        queue_insert(7'd64);
        queue_insert(7'd64);
        queue_insert(7'd127);
        queue_insert(7'd0);
        queue_insert(7'd1);
        queue_insert(7'd126);
        queue_dump();
        queue_insert(7'd63);
        queue_insert(7'd85);
        queue_insert(7'd42);
        queue_dump();

        // The sender holds off here until every result has come back.
        wait_drained();

        // Random fill: inserts with dumps mixed in until the store is full.
        n_random = 0;
        while (queued_values.size() < DEPTH) begin
            if ($urandom_range(0, 5) == 0) begin
                queue_dump();
            end else begin
                queue_insert(pick_value());
            end
            n_random++;
        end
        queue_dump();
        wait_drained();

        // Full store: inserts must now be dropped, and dumps stream all entries.
        while (n_random < 100) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_dump();
            end else begin
                queue_insert(VAL_W'($urandom_range(0, 127)));
            end
            n_random++;
        end
        wait_drained();

        // Give the block time to show any result that should not be there.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        while (awaited_results.size() > 0) begin
            report_mismatch("missing result, status",
                            -1, int'(awaited_results[0].status));
            void'(awaited_results.pop_front());
        end

        $display("covered %0d inserts, %0d dropped on full, %0d dumps, %0d empty dumps",
                 n_inserted, n_dropped, n_dumps, n_empty_dumps);
        $display("checked %0d results in %0d cycles, %0d mismatches",
                 results_checked, cycle_count, err_count);
        if (err_count == 0) begin
            $display("[descending_sorted_insert_list_top] OK");
        end else begin
            $display("[descending_sorted_insert_list_top] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/dsil_pkg.sv
design/dsil_cell.sv
design/dsil_chain.sv
design/descending_sorted_insert_list_top.sv
verif/tb_descending_sorted_insert_list_top.sv
